/* hw/rtl/wtsp_pkg.sv */
// Package with shared widths and constants of the world-to-screen projection.
`default_nettype none
package wtsp_pkg;
  localparam int COORD_W = 32;
  localparam int PIX_W = 16;
  localparam int SIZE_W = 14;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 64;
  localparam int ACC_W = 48;
  localparam int QUO_W = 19;
  localparam int NUM_W = ACC_W + SIZE_W;
  localparam int DEN_W = ACC_W + 1;
  localparam int CMP_W = DEN_W + QUO_W;
  localparam int DEF_FRACTION_BITS = 16;
  localparam logic signed [PIX_W-1:0] BEHIND_PIXEL = -16'sd640;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_X_FIRST  = 4'd0,
    REG_ROW_X_SECOND = 4'd1,
    REG_ROW_Y_FIRST  = 4'd2,
    REG_ROW_Y_SECOND = 4'd3,
    REG_ROW_W_FIRST  = 4'd4,
    REG_ROW_W_SECOND = 4'd5,
    REG_WIDTH        = 4'd6,
    REG_HEIGHT       = 4'd7
  } reg_idx_t;
endpackage
`default_nettype wire

/* hw/rtl/wtsp_if.sv */
// Channel interfaces for points, pixel results and register writes.
`default_nettype none
interface wtsp_point_if import wtsp_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [COORD_W-1:0] point_x, point_y, point_z;
  logic signed [COORD_W-1:0] offset_x, offset_y, offset_z;
  modport source(output valid, point_x, point_y, point_z, offset_x, offset_y, offset_z,
                 input ready);
  modport sink(input valid, point_x, point_y, point_z, offset_x, offset_y, offset_z,
               output ready);
endinterface

interface wtsp_pixel_if import wtsp_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [PIX_W-1:0] screen_x, screen_y;
  logic visible;
  modport source(output valid, screen_x, screen_y, visible, input ready);
  modport sink(input valid, screen_x, screen_y, visible, output ready);
endinterface

interface wtsp_cfg_if import wtsp_pkg::*; ();
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/world_to_screen_projection.sv */
// Top level of the pipelined world-to-screen projection.
//
// A word on in_ch carries a world point and an offset; a word on out_ch carries
// the pixel column, the pixel row and a visible flag. Registers are written
// through cfg, which is always ready; index 0 to 5 hold the x, y and w matrix
// rows, 6 the viewport width, 7 the height, and higher indexes are ignored.
// The pipeline has 25 register stages: offset add, products, row sums,
// magnitudes, viewport scaling, 19 stages of a restoring divider that resolve
// one quotient bit each, and the output register. One word is accepted every
// cycle while the output side takes its words.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_ch.ready drops; nothing is lost or repeated. Reset empties the pipeline
// and loads the identity-free default matrix of zeros with a 1920 by 1080
// viewport. Registers must only be written while the pipeline is empty.
`default_nettype none
module world_to_screen_projection import wtsp_pkg::*; #(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input wire logic clk,
  input wire logic rst,
  wtsp_point_if.sink in_ch,
  wtsp_pixel_if.source out_ch,
  wtsp_cfg_if.sink cfg
);
  localparam int WMIN_RAW = ((1 << FRACTION_BITS) + 500) / 1000;
  localparam int WMIN = (WMIN_RAW < 1) ? 1 : WMIN_RAW;
  localparam int SUM_W = 2 * COORD_W + 2;

  logic [CFG_DATA_W-1:0] row_x_first_pair, row_x_second_pair;
  logic [CFG_DATA_W-1:0] row_y_first_pair, row_y_second_pair;
  logic [CFG_DATA_W-1:0] row_w_first_pair, row_w_second_pair;
  logic [SIZE_W-1:0] screen_width, screen_height;

  logic signed [COORD_W-1:0] mat [3][4];
  logic en;

  logic v0, v1, v2, v3;
  logic signed [COORD_W-1:0] p [3];
  logic signed [2*COORD_W-1:0] prod [3][3];
  logic signed [ACC_W-1:0] acc [3];
  logic [ACC_W-1:0] mag_x, mag_y;
  logic [DEN_W-1:0] den3;
  logic neg_x3, neg_y3, behind3;

  logic [QUO_W:0] dv;
  logic [NUM_W-1:0] rx [QUO_W+1];
  logic [NUM_W-1:0] ry [QUO_W+1];
  logic [QUO_W-1:0] qx [QUO_W+1];
  logic [QUO_W-1:0] qy [QUO_W+1];
  logic [DEN_W-1:0] dd [QUO_W+1];
  logic nx [QUO_W+1];
  logic ny [QUO_W+1];
  logic bh [QUO_W+1];

  logic out_valid;
  logic signed [PIX_W-1:0] sx_reg, sy_reg;
  logic vis_reg;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      row_x_first_pair <= '0;
      row_x_second_pair <= '0;
      row_y_first_pair <= '0;
      row_y_second_pair <= '0;
      row_w_first_pair <= '0;
      row_w_second_pair <= '0;
      screen_width <= SIZE_W'(1920);
      screen_height <= SIZE_W'(1080);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ROW_X_FIRST: row_x_first_pair <= cfg.data;
        REG_ROW_X_SECOND: row_x_second_pair <= cfg.data;
        REG_ROW_Y_FIRST: row_y_first_pair <= cfg.data;
        REG_ROW_Y_SECOND: row_y_second_pair <= cfg.data;
        REG_ROW_W_FIRST: row_w_first_pair <= cfg.data;
        REG_ROW_W_SECOND: row_w_second_pair <= cfg.data;
        REG_WIDTH: screen_width <= cfg.data[SIZE_W-1:0];
        REG_HEIGHT: screen_height <= cfg.data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    mat[0][0] = row_x_first_pair[31:0];
    mat[0][1] = row_x_first_pair[63:32];
    mat[0][2] = row_x_second_pair[31:0];
    mat[0][3] = row_x_second_pair[63:32];
    mat[1][0] = row_y_first_pair[31:0];
    mat[1][1] = row_y_first_pair[63:32];
    mat[1][2] = row_y_second_pair[31:0];
    mat[1][3] = row_y_second_pair[63:32];
    mat[2][0] = row_w_first_pair[31:0];
    mat[2][1] = row_w_first_pair[63:32];
    mat[2][2] = row_w_second_pair[31:0];
    mat[2][3] = row_w_second_pair[63:32];
  end

  assign en = !out_valid || out_ch.ready;
  assign in_ch.ready = en;

  function automatic logic signed [COORD_W-1:0] sat_add(
    input logic signed [COORD_W-1:0] a, input logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] s;
    s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    if (s[COORD_W] != s[COORD_W-1])
      return s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    return s[COORD_W-1:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] row_sum(
    input logic signed [2*COORD_W-1:0] a, input logic signed [2*COORD_W-1:0] b,
    input logic signed [2*COORD_W-1:0] c, input logic signed [COORD_W-1:0] t);
    logic signed [SUM_W-1:0] s;
    s = SUM_W'(a >>> FRACTION_BITS) + SUM_W'(b >>> FRACTION_BITS)
      + SUM_W'(c >>> FRACTION_BITS) + SUM_W'(t);
    if (s > $signed(SUM_W'({1'b0, {(ACC_W-1){1'b1}}})))
      return {1'b0, {(ACC_W-1){1'b1}}};
    if (s < -$signed(SUM_W'({1'b1, {(ACC_W-1){1'b0}}})))
      return {1'b1, {(ACC_W-1){1'b0}}};
    return s[ACC_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v0 <= in_ch.valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p[0] <= sat_add(in_ch.point_x, in_ch.offset_x);
      p[1] <= sat_add(in_ch.point_y, in_ch.offset_y);
      p[2] <= sat_add(in_ch.point_z, in_ch.offset_z);
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= mat[r][c] * p[c];
        end
        acc[r] <= row_sum(prod[r][0], prod[r][1], prod[r][2], mat[r][3]);
      end
      neg_x3 <= acc[0][ACC_W-1];
      mag_x <= acc[0][ACC_W-1] ? -acc[0] : acc[0];
      neg_y3 <= (acc[1] > 0);
      mag_y <= acc[1][ACC_W-1] ? -acc[1] : acc[1];
      den3 <= {acc[2], 1'b0};
      behind3 <= (acc[2] < ACC_W'(WMIN));
      rx[0] <= mag_x * screen_width;
      ry[0] <= mag_y * screen_height;
      qx[0] <= '0;
      qy[0] <= '0;
      dd[0] <= den3;
      nx[0] <= neg_x3;
      ny[0] <= neg_y3;
      bh[0] <= behind3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else if (en) dv[0] <= v3;
  end

  for (genvar i = 0; i < QUO_W; i++) begin : g_div
    localparam int SH = QUO_W - 1 - i;
    logic [CMP_W-1:0] dshift;
    logic gx, gy;
    assign dshift = CMP_W'(dd[i]) << SH;
    assign gx = CMP_W'(rx[i]) >= dshift;
    assign gy = CMP_W'(ry[i]) >= dshift;
    always_ff @(posedge clk) begin
      if (rst) dv[i+1] <= 1'b0;
      else if (en) dv[i+1] <= dv[i];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rx[i+1] <= gx ? NUM_W'(CMP_W'(rx[i]) - dshift) : rx[i];
        ry[i+1] <= gy ? NUM_W'(CMP_W'(ry[i]) - dshift) : ry[i];
        qx[i+1] <= qx[i] | (QUO_W'(gx) << SH);
        qy[i+1] <= qy[i] | (QUO_W'(gy) << SH);
        dd[i+1] <= dd[i];
        nx[i+1] <= nx[i];
        ny[i+1] <= ny[i];
        bh[i+1] <= bh[i];
      end
    end
  end

  function automatic logic signed [PIX_W-1:0] to_pixel(
    input logic [QUO_W-1:0] q, input logic neg, input logic [SIZE_W-1:0] size);
    logic signed [QUO_W+1:0] a, k;
    if (q[QUO_W-1])
      return neg ? {1'b1, {(PIX_W-1){1'b0}}} : {1'b0, {(PIX_W-1){1'b1}}};
    a = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
    k = a + $signed((QUO_W+2)'(size >> 1));
    if (size[0] && k < 0)
      k = k + 1;
    if (k > (QUO_W+2)'(32767))
      return {1'b0, {(PIX_W-1){1'b1}}};
    if (k < -(QUO_W+2)'(32768))
      return {1'b1, {(PIX_W-1){1'b0}}};
    return k[PIX_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= dv[QUO_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (bh[QUO_W]) begin
        sx_reg <= BEHIND_PIXEL;
        sy_reg <= BEHIND_PIXEL;
        vis_reg <= 1'b0;
      end else begin
        sx_reg <= to_pixel(qx[QUO_W], nx[QUO_W], screen_width);
        sy_reg <= to_pixel(qy[QUO_W], ny[QUO_W], screen_height);
        vis_reg <= 1'b1;
      end
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.screen_x = sx_reg;
  assign out_ch.screen_y = sy_reg;
  assign out_ch.visible = vis_reg;
endmodule
`default_nettype wire

/* verif/world_to_screen_projection_tb.sv */
// Self-checking testbench of the world-to-screen projection: random and directed points.
`timescale 1ns / 100ps
`default_nettype none

typedef struct {
  int px, py, pz;
  int ox, oy, oz;
} world_point_t;

typedef struct {
  logic signed [15:0] sx;
  logic signed [15:0] sy;
  logic vis;
} pixel_t;

class projection_tracker;
  logic [63:0] matrix_regs[6];
  logic [13:0] view_w, view_h;
  pixel_t pending_pixels[$];
  int errors;
  int checked;
  int visible_seen;

  function new();
    foreach (matrix_regs[i]) matrix_regs[i] = '0;
    view_w = 14'd1920;
    view_h = 14'd1080;
  endfunction

  function void set_reg(wtsp_pkg::reg_idx_t idx, logic [63:0] value);
    if (idx == wtsp_pkg::REG_WIDTH) view_w = value[13:0];
    else if (idx == wtsp_pkg::REG_HEIGHT) view_h = value[13:0];
    else matrix_regs[idx] = value;
  endfunction

  function longint clamp(longint v, int bits);
    longint hi, lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function longint row_sum(logic [63:0] first, logic [63:0] second, longint q[3]);
    longint acc;
    acc = ((longint'(int'(first[31:0])) * q[0]) >>> 16)
        + ((longint'(int'(first[63:32])) * q[1]) >>> 16)
        + ((longint'(int'(second[31:0])) * q[2]) >>> 16)
        + longint'(int'(second[63:32]));
    return clamp(acc, 48);
  endfunction

  function longint center(longint a, longint size);
    longint k;
    k = a + size / 2;
    if (size[0] && k < 0) k += 1;
    return k;
  endfunction

  function pixel_t project_point(world_point_t p);
    longint q[3];
    longint cx, cy, cw, wd, ht, a, b;
    pixel_t r;
    q[0] = clamp(longint'(p.px) + longint'(p.ox), 32);
    q[1] = clamp(longint'(p.py) + longint'(p.oy), 32);
    q[2] = clamp(longint'(p.pz) + longint'(p.oz), 32);
    cx = row_sum(matrix_regs[0], matrix_regs[1], q);
    cy = row_sum(matrix_regs[2], matrix_regs[3], q);
    cw = row_sum(matrix_regs[4], matrix_regs[5], q);
    if (cw < 66) begin
      r.sx = wtsp_pkg::BEHIND_PIXEL;
      r.sy = wtsp_pkg::BEHIND_PIXEL;
      r.vis = 1'b0;
      return r;
    end
    wd = longint'(view_w);
    ht = longint'(view_h);
    a = (cx * wd) / (2 * cw);
    b = -((cy * ht) / (2 * cw));
    r.sx = 16'(clamp(center(a, wd), 16));
    r.sy = 16'(clamp(center(b, ht), 16));
    r.vis = 1'b1;
    return r;
  endfunction

  function void note_point(world_point_t p);
    pending_pixels.push_back(project_point(p));
  endfunction

  task report(string what, int got, int want);
    $display("MISMATCH at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  task check_pixel(logic signed [15:0] sx, logic signed [15:0] sy, logic vis);
    pixel_t e;
    if (pending_pixels.size() == 0) begin
      report("unexpected word, screen_x", sx, 0);
      return;
    end
    e = pending_pixels.pop_front();
    checked++;
    if (vis) visible_seen++;
    if (sx !== e.sx) report("screen_x", sx, e.sx);
    if (sy !== e.sy) report("screen_y", sy, e.sy);
    if (vis !== e.vis) report("visible", vis, e.vis);
  endtask
endclass

module world_to_screen_projection_tb;
  import wtsp_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int ONE = 32'h10000;

  logic clk;
  logic rst;
  int idle_cycles;
  bit long_hold;
  bit no_gaps;
  projection_tracker tracker;

  wtsp_point_if in_ch();
  wtsp_pixel_if out_ch();
  wtsp_cfg_if cfg();

  world_to_screen_projection dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source),
    .cfg(cfg.sink)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  initial begin
    tracker = new();
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.point_x <= '0;
    in_ch.point_y <= '0;
    in_ch.point_z <= '0;
    in_ch.offset_x <= '0;
    in_ch.offset_y <= '0;
    in_ch.offset_z <= '0;
    out_ch.ready <= 1'b0;
    cfg.valid <= 1'b0;
    cfg.index <= '0;
    cfg.data <= '0;
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg.valid && cfg.ready) || rst) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles.", IDLE_LIMIT);
      $display("world_to_screen_projection_tb: done, errors");
      $finish;
    end
  end

  initial begin
    int gap;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (200) @(posedge clk);
        long_hold = 1'b0;
      end
      gap = no_gaps ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      tracker.check_pixel(out_ch.screen_x, out_ch.screen_y, out_ch.visible);
    end
  end

  task automatic send_point(world_point_t p);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.point_x <= p.px;
    in_ch.point_y <= p.py;
    in_ch.point_z <= p.pz;
    in_ch.offset_x <= p.ox;
    in_ch.offset_y <= p.oy;
    in_ch.offset_z <= p.oz;
    do @(posedge clk); while (!in_ch.ready);
    tracker.note_point(p);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (tracker.pending_pixels.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [63:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
    tracker.set_reg(idx, value);
  endtask

  task automatic load_view(logic [63:0] m[6], int w, int h);
    for (int i = 0; i < 6; i++) write_reg(reg_idx_t'(i), m[i]);
    write_reg(REG_WIDTH, 64'(w));
    write_reg(REG_HEIGHT, 64'(h));
    cfg.valid <= 1'b0;
  endtask

  function automatic world_point_t make_point(bit noisy);
    world_point_t p;
    int depth;
    if (noisy) begin
      p = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      if ($urandom_range(0, 1)) p.oz = 0;
      return p;
    end
    depth = $urandom_range(1, 2000);
    p.pz = depth * ONE + $urandom_range(0, ONE - 1);
    p.px = $signed($urandom_range(0, 2 * depth)) * ONE - depth * ONE + $urandom_range(0, 65535);
    p.py = $signed($urandom_range(0, 2 * depth)) * ONE - depth * ONE + $urandom_range(0, 65535);
    p.ox = 0;
    p.oy = 0;
    p.oz = 0;
    if ($urandom_range(0, 2) == 0) begin
      p.ox = $signed($urandom_range(0, 2 * ONE)) - ONE;
      p.oy = $signed($urandom_range(0, 2 * ONE)) - ONE;
      p.oz = $signed($urandom_range(0, 2 * ONE)) - ONE;
    end
    if ($urandom_range(0, 9) == 0) p.pz = -p.pz;
    return p;
  endfunction

  task automatic random_points(int count, int noise_pct);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      send_point(make_point($urandom_range(1, 100) <= noise_pct));
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    logic [63:0] m[6];
    world_point_t d[$];
    int imax, imin;
    imax = 32'sh7FFFFFFF;
    imin = 32'sh80000000;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Default registers: a zero matrix puts every point behind the viewer.
    random_points(20, 50);
    drain();

    // Plain perspective: w follows z, with a small translation in x and y.
    m[0] = {32'h0000_0000, 32'(ONE)};
    m[1] = {32'(5 * ONE), 32'h0};
    m[2] = {32'(ONE), 32'h0};
    m[3] = {32'(-3 * ONE), 32'h0};
    m[4] = 64'h0;
    m[5] = {32'h0, 32'(ONE)};
    load_view(m, 1279, 719);
    d = '{
      '{0, 0, 65, 0, 0, 0}, '{0, 0, 66, 0, 0, 0}, '{0, 0, 0, 0, 0, 0},
      '{0, 0, -ONE, 0, 0, 0}, '{imax, imax, imax, imax, imax, imax},
      '{imin, imin, imin, imin, imin, imin}, '{imax, imin, ONE, 0, 0, 0},
      '{imin, imax, 66, 0, 0, 0}, '{imax, 0, imin, 0, 0, imax},
      '{-ONE, ONE, ONE, 0, 0, 0}, '{ONE, -ONE, ONE, 0, 0, 0},
      '{ONE, ONE, 2 * ONE, -ONE, -ONE, -ONE}, '{-7 * ONE, -5, ONE, 2, 3, 0},
      '{0, 0, ONE, imin, imax, imax}, '{1, -1, 66, -1, 1, 0},
      '{imax, imax, 70, 0, 0, 0}, '{-imax, -imax, 70, 0, 0, 0},
      '{12345678, -87654321, 5 * ONE, 0, 0, 0}
    };
    foreach (d[i]) send_point(d[i]);
    random_points(110, 25);
    // The receiver holds off while points keep coming, so the pipeline fills.
    long_hold = 1'b1;
    random_points(40, 25);
    drain();

    // Even full-size viewport with a tilted matrix.
    m[0] = {32'(ONE / 4), 32'(ONE)};
    m[1] = {32'(ONE), 32'(ONE / 8)};
    m[2] = {32'(ONE), 32'(-ONE / 4)};
    m[3] = {32'h0, 32'(ONE / 8)};
    m[4] = {32'(ONE / 16), 32'h0};
    m[5] = {32'(ONE / 2), 32'(ONE)};
    load_view(m, 1920, 1080);
    random_points(120, 20);
    drain();

    // A wide, one-row viewport with random matrix entries; the z weight of w stays non-negative.
    foreach (m[i]) m[i] = {$urandom, $urandom};
    m[5][31] = 1'b0;
    load_view(m, 8192, 1);
    random_points(80, 60);
    drain();

    m[0] = {32'h8000_0000, 32'h7FFF_FFFF};
    m[1] = {32'h7FFF_FFFF, 32'h8000_0000};
    m[2] = {32'h8000_0000, 32'h8000_0000};
    m[3] = {32'h7FFF_FFFF, 32'h7FFF_FFFF};
    m[4] = {32'h0, 32'h0};
    m[5] = {32'h7FFF_FFFF, 32'h7FFF_FFFF};
    load_view(m, 1, 8192);
    random_points(80, 60);
    drain();

    // A zero viewport size maps every visible point to pixel zero.
    m[4] = 64'h0;
    m[5] = {32'(ONE), 32'(ONE)};
    load_view(m, 0, 0);
    random_points(60, 40);
    drain();

    $display("Checked %0d pixel words, %0d of them visible, over six register settings.",
             tracker.checked, tracker.visible_seen);
    $display("Settings ranged from a zero matrix to extreme entries and viewport sizes.");
    if (tracker.errors == 0 && tracker.pending_pixels.size() == 0) begin
      $display("world_to_screen_projection_tb: done, clean");
    end else begin
      $display("world_to_screen_projection_tb: done, errors");
    end
    $finish;
  end
endmodule

`default_nettype wire

/* filelist.f */
hw/rtl/wtsp_pkg.sv
hw/rtl/wtsp_if.sv
hw/rtl/world_to_screen_projection.sv
verif/world_to_screen_projection_tb.sv
